FILE: sv/icrf_pkg.sv
// Shared types and constants for the interrupt control register file.
package icrf_pkg;

  localparam int unsigned RowCount  = 4;
  localparam int unsigned LaneCount = 4;
  localparam int unsigned RowW      = 2;
  localparam int unsigned LaneW     = 2;

  // Flag bytes live in row 0, lanes 2 and 3
  localparam logic [RowW-1:0]  FlagRow    = 2'd0;
  localparam logic [LaneW-1:0] FlagLaneLo = 2'd2;
  localparam logic [LaneW-1:0] FlagLaneHi = 2'd3;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RAISE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    WIDTH_BYTE = 2'd0,
    WIDTH_HALF = 2'd1,
    WIDTH_WORD = 2'd2,
    WIDTH_WIDE = 2'd3
  } width_t;

  typedef struct packed {
    logic                 wr_en;
    logic                 raise_en;
    logic [RowW-1:0]      row;
    logic [LaneCount-1:0] byte_en;
    logic [31:0]          wdata;
    logic [15:0]          irq;
  } reg_req_t;

endpackage

FILE: sv/interrupt_control_register_file_core.sv
// Interrupt control register file: input register, access logic, result register.
// A read item passes through the input register and then the result register.
// Throughput: one item per cycle; a read stalls only while the result register is full
// and not being taken. Writes and raises take effect when they leave the input register.
// Reset (rst_n low, synchronous) clears all sixteen bytes and both valid flags.
module interrupt_control_register_file_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_offset,
  input  logic [1:0]  in_access_width,
  input  logic [31:0] in_write_data,
  input  logic [15:0] in_irq_lines,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data
);

  logic        s_valid_r;
  logic [1:0]  s_kind_r;
  logic [3:0]  s_offset_r;
  logic [1:0]  s_width_r;
  logic [31:0] s_wdata_r;
  logic [15:0] s_irq_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_data_r;

  logic        fire;
  logic        is_read;
  logic [3:0]  base;
  logic [1:0]  lane;
  logic [3:0]  byte_en;
  logic [31:0] row_data;
  logic [31:0] rd_shift;
  logic [31:0] rd_value;
  icrf_pkg::reg_req_t req;

  assign is_read  = s_kind_r == icrf_pkg::KIND_READ;
  assign fire     = s_valid_r && (!is_read || !out_valid_r || out_ready);
  assign in_ready = !s_valid_r || fire;

  // align the offset down and pick the byte lanes
  always_comb begin
    case (s_width_r)
      icrf_pkg::WIDTH_BYTE: begin
        base    = s_offset_r;
        byte_en = 4'b0001 << s_offset_r[1:0];
      end
      icrf_pkg::WIDTH_HALF: begin
        base    = {s_offset_r[3:1], 1'b0};
        byte_en = 4'b0011 << {s_offset_r[1], 1'b0};
      end
      default: begin
        base    = {s_offset_r[3:2], 2'b00};
        byte_en = 4'b1111;
      end
    endcase
  end

  assign lane = base[1:0];

  always_comb begin
    req.wr_en    = fire && s_kind_r == icrf_pkg::KIND_WRITE;
    req.raise_en = fire && s_kind_r == icrf_pkg::KIND_RAISE;
    req.row      = base[3:2];
    req.byte_en  = byte_en;
    req.wdata    = s_wdata_r << {lane, 3'b000};
    req.irq      = s_irq_r;
  end

  icrf_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .row_data (row_data)
  );

  assign rd_shift = row_data >> {lane, 3'b000};

  always_comb begin
    case (s_width_r)
      icrf_pkg::WIDTH_BYTE: rd_value = {24'h0, rd_shift[7:0]};
      icrf_pkg::WIDTH_HALF: rd_value = {16'h0, rd_shift[15:0]};
      default:              rd_value = rd_shift;
    endcase
  end

  always_comb begin
    if (fire && is_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_kind_r   <= in_kind;
      s_offset_r <= in_offset;
      s_width_r  <= in_access_width;
      s_wdata_r  <= in_write_data;
      s_irq_r    <= in_irq_lines;
    end
    if (fire && is_read) begin
      out_data_r <= rd_value;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

`ifndef NO_ASSERTIONS
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_read |=> out_valid_r)
    else $error("read item left no result");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire && is_read))
    else $error("result appeared without a read item");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s_valid_r && is_read && out_valid_r)
    else $error("input stalled with no blocked read");
`endif

endmodule

FILE: sv/icrf_regs.sv
// Register storage: four 32-bit rows with write-one-to-clear flag bytes.
module icrf_regs (
  input  logic                   clk,
  input  logic                   rst_n,
  input  icrf_pkg::reg_req_t     req,
  output logic [31:0]            row_data
);

  logic [icrf_pkg::RowCount-1:0][31:0] rows_r;
  logic [icrf_pkg::RowCount-1:0][31:0] rows_nxt;

  assign row_data = rows_r[req.row];

  always_comb begin
    rows_nxt = rows_r;
    for (int r = 0; r < icrf_pkg::RowCount; r++) begin
      for (int l = 0; l < icrf_pkg::LaneCount; l++) begin
        if (req.wr_en && req.row == icrf_pkg::RowW'(r) && req.byte_en[l]) begin
          if (icrf_pkg::RowW'(r) == icrf_pkg::FlagRow &&
              (icrf_pkg::LaneW'(l) == icrf_pkg::FlagLaneLo ||
               icrf_pkg::LaneW'(l) == icrf_pkg::FlagLaneHi)) begin
            // clear flag bits where the written byte has ones
            rows_nxt[r][l*8 +: 8] = rows_r[r][l*8 +: 8] & ~req.wdata[l*8 +: 8];
          end else begin
            rows_nxt[r][l*8 +: 8] = req.wdata[l*8 +: 8];
          end
        end
      end
    end
    if (req.raise_en) begin
      rows_nxt[icrf_pkg::FlagRow][16 +: 16] = rows_r[icrf_pkg::FlagRow][16 +: 16] | req.irq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
    end else begin
      rows_r <= rows_nxt;
    end
  end

endmodule
